// File: rtl/esc_pkg.sv
// Shared types, constants and the back-end microprogram of the sensor
// compensation core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

  localparam int unsigned PC_W      = 7;
  localparam logic [6:0]  LAST_PC   = 7'd77;
  localparam int unsigned DIV_CNT_W = 7;
  localparam logic [6:0]  DIV_STEPS = 7'd64;

  typedef struct packed {
    logic [19:0] adc_p;
    logic [19:0] adc_t;
    logic [15:0] adc_h;
  } item_t;

  typedef struct packed {
    logic        hum_en;
    logic [47:0] cal_temp;
    logic [63:0] cal_press_a;
    logic [63:0] cal_press_b;
    logic [15:0] cal_press_c;
    logic [63:0] cal_hum;
  } cfg_t;

  typedef enum logic [2:0] {
    CFG_HUM_EN  = 3'd0,
    CFG_TEMP    = 3'd1,
    CFG_PRESS_A = 3'd2,
    CFG_PRESS_B = 3'd3,
    CFG_PRESS_C = 3'd4,
    CFG_HUM     = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_SHL, OP_ASR, OP_DIV, OP_MIN, OP_MAX
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_EXEC, BK_MUL, BK_DIV, BK_EMIT
  } bk_state_t;

  // Operand codes: working registers, constants, item and coefficient fields
  localparam logic [5:0] R0 = 6'd0;
  localparam logic [5:0] R1 = 6'd1;
  localparam logic [5:0] R2 = 6'd2;
  localparam logic [5:0] R3 = 6'd3;
  localparam logic [5:0] R4 = 6'd4;
  localparam logic [5:0] R5 = 6'd5;
  localparam logic [5:0] R6 = 6'd6;
  localparam logic [5:0] R7 = 6'd7;
  localparam logic [5:0] K0        = 6'd16;
  localparam logic [5:0] K5        = 6'd17;
  localparam logic [5:0] K128      = 6'd18;
  localparam logic [5:0] K32767    = 6'd19;
  localparam logic [5:0] KM32768   = 6'd20;
  localparam logic [5:0] K128000   = 6'd21;
  localparam logic [5:0] K2P47     = 6'd22;
  localparam logic [5:0] K1048576  = 6'd23;
  localparam logic [5:0] K3125     = 6'd24;
  localparam logic [5:0] K76800    = 6'd25;
  localparam logic [5:0] K16384    = 6'd26;
  localparam logic [5:0] K32768    = 6'd27;
  localparam logic [5:0] K2097152  = 6'd28;
  localparam logic [5:0] K8192     = 6'd29;
  localparam logic [5:0] KHUMMAX   = 6'd30;
  localparam logic [5:0] F_ADCP = 6'd32;
  localparam logic [5:0] F_ADCT = 6'd33;
  localparam logic [5:0] F_ADCH = 6'd34;
  localparam logic [5:0] F_T1 = 6'd35;
  localparam logic [5:0] F_T2 = 6'd36;
  localparam logic [5:0] F_T3 = 6'd37;
  localparam logic [5:0] F_P1 = 6'd38;
  localparam logic [5:0] F_P2 = 6'd39;
  localparam logic [5:0] F_P3 = 6'd40;
  localparam logic [5:0] F_P4 = 6'd41;
  localparam logic [5:0] F_P5 = 6'd42;
  localparam logic [5:0] F_P6 = 6'd43;
  localparam logic [5:0] F_P7 = 6'd44;
  localparam logic [5:0] F_P8 = 6'd45;
  localparam logic [5:0] F_P9 = 6'd46;
  localparam logic [5:0] F_H1 = 6'd47;
  localparam logic [5:0] F_H2 = 6'd48;
  localparam logic [5:0] F_H3 = 6'd49;
  localparam logic [5:0] F_H4 = 6'd50;
  localparam logic [5:0] F_H5 = 6'd51;
  localparam logic [5:0] F_H6 = 6'd52;

  typedef struct packed {
    op_t        op;
    logic       w32;
    logic [2:0] dst;
    logic [5:0] sa;
    logic [5:0] sb;
    logic [5:0] sh;
  } uword_t;

  function automatic uword_t mk(op_t op, logic w32, logic [5:0] dst,
                                logic [5:0] sa, logic [5:0] sb, logic [5:0] sh);
    uword_t u;
    u.op  = op;
    u.w32 = w32;
    u.dst = dst[2:0];
    u.sa  = sa;
    u.sb  = sb;
    u.sh  = sh;
    return u;
  endfunction

  function automatic uword_t ucode(logic [6:0] pc);
    uword_t u;
    case (pc)
      // temperature, 32-bit wrap; t_fine in R2, result in R3
      7'd0:  u = mk(OP_ASR, 1'b1, R0, F_ADCT, K0, 6'd3);
      7'd1:  u = mk(OP_SHL, 1'b1, R1, F_T1, K0, 6'd1);
      7'd2:  u = mk(OP_SUB, 1'b1, R0, R0, R1, 6'd0);
      7'd3:  u = mk(OP_MUL, 1'b1, R0, R0, F_T2, 6'd0);
      7'd4:  u = mk(OP_ASR, 1'b1, R0, R0, K0, 6'd11);
      7'd5:  u = mk(OP_ASR, 1'b1, R1, F_ADCT, K0, 6'd4);
      7'd6:  u = mk(OP_SUB, 1'b1, R1, R1, F_T1, 6'd0);
      7'd7:  u = mk(OP_MUL, 1'b1, R1, R1, R1, 6'd0);
      7'd8:  u = mk(OP_ASR, 1'b1, R1, R1, K0, 6'd12);
      7'd9:  u = mk(OP_MUL, 1'b1, R1, R1, F_T3, 6'd0);
      7'd10: u = mk(OP_ASR, 1'b1, R1, R1, K0, 6'd14);
      7'd11: u = mk(OP_ADD, 1'b1, R2, R0, R1, 6'd0);
      7'd12: u = mk(OP_MUL, 1'b1, R0, R2, K5, 6'd0);
      7'd13: u = mk(OP_ADD, 1'b1, R0, R0, K128, 6'd0);
      7'd14: u = mk(OP_ASR, 1'b1, R0, R0, K0, 6'd8);
      7'd15: u = mk(OP_MIN, 1'b1, R0, R0, K32767, 6'd0);
      7'd16: u = mk(OP_MAX, 1'b1, R3, R0, KM32768, 6'd0);
      // pressure, 64-bit wrap; divisor stays in R0, result in R1
      7'd17: u = mk(OP_SUB, 1'b0, R0, R2, K128000, 6'd0);
      7'd18: u = mk(OP_MUL, 1'b0, R1, R0, R0, 6'd0);
      7'd19: u = mk(OP_MUL, 1'b0, R4, R1, F_P6, 6'd0);
      7'd20: u = mk(OP_MUL, 1'b0, R5, R0, F_P5, 6'd0);
      7'd21: u = mk(OP_SHL, 1'b0, R5, R5, K0, 6'd17);
      7'd22: u = mk(OP_ADD, 1'b0, R4, R4, R5, 6'd0);
      7'd23: u = mk(OP_SHL, 1'b0, R5, F_P4, K0, 6'd35);
      7'd24: u = mk(OP_ADD, 1'b0, R4, R4, R5, 6'd0);
      7'd25: u = mk(OP_MUL, 1'b0, R1, R1, F_P3, 6'd0);
      7'd26: u = mk(OP_ASR, 1'b0, R1, R1, K0, 6'd8);
      7'd27: u = mk(OP_MUL, 1'b0, R5, R0, F_P2, 6'd0);
      7'd28: u = mk(OP_SHL, 1'b0, R5, R5, K0, 6'd12);
      7'd29: u = mk(OP_ADD, 1'b0, R0, R1, R5, 6'd0);
      7'd30: u = mk(OP_ADD, 1'b0, R0, R0, K2P47, 6'd0);
      7'd31: u = mk(OP_MUL, 1'b0, R0, R0, F_P1, 6'd0);
      7'd32: u = mk(OP_ASR, 1'b0, R0, R0, K0, 6'd33);
      7'd33: u = mk(OP_SUB, 1'b0, R1, K1048576, F_ADCP, 6'd0);
      7'd34: u = mk(OP_SHL, 1'b0, R1, R1, K0, 6'd31);
      7'd35: u = mk(OP_SUB, 1'b0, R1, R1, R4, 6'd0);
      7'd36: u = mk(OP_MUL, 1'b0, R1, R1, K3125, 6'd0);
      7'd37: u = mk(OP_DIV, 1'b0, R1, R1, R0, 6'd0);
      7'd38: u = mk(OP_ASR, 1'b0, R5, R1, K0, 6'd13);
      7'd39: u = mk(OP_MUL, 1'b0, R6, F_P9, R5, 6'd0);
      7'd40: u = mk(OP_MUL, 1'b0, R6, R6, R5, 6'd0);
      7'd41: u = mk(OP_ASR, 1'b0, R6, R6, K0, 6'd25);
      7'd42: u = mk(OP_MUL, 1'b0, R7, F_P8, R1, 6'd0);
      7'd43: u = mk(OP_ASR, 1'b0, R7, R7, K0, 6'd19);
      7'd44: u = mk(OP_ADD, 1'b0, R1, R1, R6, 6'd0);
      7'd45: u = mk(OP_ADD, 1'b0, R1, R1, R7, 6'd0);
      7'd46: u = mk(OP_ASR, 1'b0, R1, R1, K0, 6'd8);
      7'd47: u = mk(OP_SHL, 1'b0, R7, F_P7, K0, 6'd4);
      7'd48: u = mk(OP_ADD, 1'b0, R1, R1, R7, 6'd0);
      // humidity, 32-bit wrap; result in R5
      7'd49: u = mk(OP_SUB, 1'b1, R4, R2, K76800, 6'd0);
      7'd50: u = mk(OP_SHL, 1'b1, R5, F_ADCH, K0, 6'd14);
      7'd51: u = mk(OP_SHL, 1'b1, R6, F_H4, K0, 6'd20);
      7'd52: u = mk(OP_SUB, 1'b1, R5, R5, R6, 6'd0);
      7'd53: u = mk(OP_MUL, 1'b1, R6, F_H5, R4, 6'd0);
      7'd54: u = mk(OP_SUB, 1'b1, R5, R5, R6, 6'd0);
      7'd55: u = mk(OP_ADD, 1'b1, R5, R5, K16384, 6'd0);
      7'd56: u = mk(OP_ASR, 1'b1, R5, R5, K0, 6'd15);
      7'd57: u = mk(OP_MUL, 1'b1, R6, R4, F_H6, 6'd0);
      7'd58: u = mk(OP_ASR, 1'b1, R6, R6, K0, 6'd10);
      7'd59: u = mk(OP_MUL, 1'b1, R7, R4, F_H3, 6'd0);
      7'd60: u = mk(OP_ASR, 1'b1, R7, R7, K0, 6'd11);
      7'd61: u = mk(OP_ADD, 1'b1, R7, R7, K32768, 6'd0);
      7'd62: u = mk(OP_MUL, 1'b1, R6, R6, R7, 6'd0);
      7'd63: u = mk(OP_ASR, 1'b1, R6, R6, K0, 6'd10);
      7'd64: u = mk(OP_ADD, 1'b1, R6, R6, K2097152, 6'd0);
      7'd65: u = mk(OP_MUL, 1'b1, R6, R6, F_H2, 6'd0);
      7'd66: u = mk(OP_ADD, 1'b1, R6, R6, K8192, 6'd0);
      7'd67: u = mk(OP_ASR, 1'b1, R6, R6, K0, 6'd14);
      7'd68: u = mk(OP_MUL, 1'b1, R5, R5, R6, 6'd0);
      7'd69: u = mk(OP_ASR, 1'b1, R6, R5, K0, 6'd15);
      7'd70: u = mk(OP_MUL, 1'b1, R6, R6, R6, 6'd0);
      7'd71: u = mk(OP_ASR, 1'b1, R6, R6, K0, 6'd7);
      7'd72: u = mk(OP_MUL, 1'b1, R6, R6, F_H1, 6'd0);
      7'd73: u = mk(OP_ASR, 1'b1, R6, R6, K0, 6'd4);
      7'd74: u = mk(OP_SUB, 1'b1, R5, R5, R6, 6'd0);
      7'd75: u = mk(OP_MAX, 1'b1, R5, R5, K0, 6'd0);
      7'd76: u = mk(OP_MIN, 1'b1, R5, R5, KHUMMAX, 6'd0);
      7'd77: u = mk(OP_ASR, 1'b1, R5, R5, K0, 6'd12);
      default: u = mk(OP_ADD, 1'b0, R0, R0, K0, 6'd0);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// File: rtl/env_sensor_compensation_core.sv
// Top level: configuration registers, front end, item queue and back end.
// The back end computes one item at a time, paced by the single shared 32x32
// multiplier (three partial products per 64-bit result) and the divider.
// busy is high while the two-entry queue is full; results cannot be stalled.
// Reset clears all configuration registers to zero and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module env_sensor_compensation_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_press_msb,
  input  wire logic [7:0]  in_press_lsb,
  input  wire logic [7:0]  in_press_xlsb,
  input  wire logic [7:0]  in_temp_msb,
  input  wire logic [7:0]  in_temp_lsb,
  input  wire logic [7:0]  in_temp_xlsb,
  input  wire logic [7:0]  in_hum_msb,
  input  wire logic [7:0]  in_hum_lsb,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [63:0] cfg_wdata,
  output logic             out_valid,
  output logic [15:0]      out_temperature_centi,
  output logic [31:0]      out_pressure_q24_8,
  output logic             out_pressure_div_zero,
  output logic [16:0]      out_humidity_q22_10,
  output logic             out_humidity_valid
);
  import esc_pkg::*;

  cfg_t  cfg_r;
  item_t f_item, q_head;
  logic  f_push, q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_HUM_EN:  cfg_r.hum_en      <= cfg_wdata[0];
        CFG_TEMP:    cfg_r.cal_temp    <= cfg_wdata[47:0];
        CFG_PRESS_A: cfg_r.cal_press_a <= cfg_wdata;
        CFG_PRESS_B: cfg_r.cal_press_b <= cfg_wdata;
        CFG_PRESS_C: cfg_r.cal_press_c <= cfg_wdata[15:0];
        CFG_HUM:     cfg_r.cal_hum     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  esc_front u_front (
    .start      (start),
    .press_msb  (in_press_msb),
    .press_lsb  (in_press_lsb),
    .press_xlsb (in_press_xlsb),
    .temp_msb   (in_temp_msb),
    .temp_lsb   (in_temp_lsb),
    .temp_xlsb  (in_temp_xlsb),
    .hum_msb    (in_hum_msb),
    .hum_lsb    (in_hum_lsb),
    .q_full     (q_full),
    .busy       (busy),
    .push       (f_push),
    .item       (f_item)
  );

  esc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  esc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .q_empty               (q_empty),
    .q_head                (q_head),
    .pop                   (q_pop),
    .out_valid             (out_valid),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_q24_8    (out_pressure_q24_8),
    .out_pressure_div_zero (out_pressure_div_zero),
    .out_humidity_q22_10   (out_humidity_q22_10),
    .out_humidity_valid    (out_humidity_valid)
  );

endmodule
`default_nettype wire

// File: rtl/esc_queue.sv
// Two-entry item queue between the front and the back end.
// Depends on esc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module esc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire esc_pkg::item_t push_item,
  input  wire logic          pop,
  output logic               full,
  output logic               empty,
  output esc_pkg::item_t     head
);
  import esc_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

endmodule
`default_nettype wire

// File: rtl/esc_front.sv
// Front end: takes the burst-read bytes, unpacks the raw readings and
// queues one beat per accepted item. Depends on esc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module esc_front (
  input  wire logic       start,
  input  wire logic [7:0] press_msb,
  input  wire logic [7:0] press_lsb,
  input  wire logic [7:0] press_xlsb,
  input  wire logic [7:0] temp_msb,
  input  wire logic [7:0] temp_lsb,
  input  wire logic [7:0] temp_xlsb,
  input  wire logic [7:0] hum_msb,
  input  wire logic [7:0] hum_lsb,
  input  wire logic       q_full,
  output logic            busy,
  output logic            push,
  output esc_pkg::item_t  item
);
  import esc_pkg::*;

  assign busy       = q_full;
  assign push       = start & ~q_full;
  assign item.adc_p = {press_msb, press_lsb, press_xlsb[7:4]};
  assign item.adc_t = {temp_msb, temp_lsb, temp_xlsb[7:4]};
  assign item.adc_h = {hum_msb, hum_lsb};

endmodule
`default_nettype wire

// File: rtl/esc_div.sv
// Signed 64-bit divider, truncating, one quotient bit per cycle.
// Depends on esc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module esc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic [63:0]      quo
);
  import esc_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r, neg_r;
  logic [63:0]          q_r, rem_r, den_r;
  logic [63:0]          rem_sh;
  logic                 fits;

  assign rem_sh = {rem_r[62:0], q_r[63]};
  assign fits   = (rem_sh >= den_r);
  assign done   = done_r;
  assign quo    = neg_r ? (64'd0 - q_r) : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1));
      if (start) cnt_r <= DIV_STEPS;
      else if (cnt_r != '0) cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[63] ? (64'd0 - num) : num;
      den_r <= den[63] ? (64'd0 - den) : den;
      rem_r <= 64'd0;
      neg_r <= num[63] ^ den[63];
    end else if (cnt_r != '0) begin
      rem_r <= fits ? (rem_sh - den_r) : rem_sh;
      q_r   <= {q_r[62:0], fits};
    end
  end

endmodule
`default_nettype wire

// File: rtl/esc_back.sv
// Back end: microprogrammed datapath with a shared 32x32 multiplier and the
// divider; computes temperature, pressure and humidity. Depends on esc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module esc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire esc_pkg::cfg_t cfg,
  input  wire logic          q_empty,
  input  wire esc_pkg::item_t q_head,
  output logic               pop,
  output logic               out_valid,
  output logic [15:0]        out_temperature_centi,
  output logic [31:0]        out_pressure_q24_8,
  output logic               out_pressure_div_zero,
  output logic [16:0]        out_humidity_q22_10,
  output logic               out_humidity_valid
);
  import esc_pkg::*;

  bk_state_t   state_r, state_nxt;
  logic [6:0]  pc_r;
  logic [1:0]  mph_r, mul_ph;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] rf_r [8];
  item_t       cur_r;
  logic        valid_r;

  uword_t      uw;
  logic [63:0] src [64];
  logic [63:0] opa, opb, alu_res, wdata_raw, wdata;
  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic        rf_we, pc_adv, acc_ld, div_start, out_load, last;
  logic        div_done;
  logic [63:0] div_quo;

  assign uw   = ucode(pc_r);
  assign last = (pc_r == LAST_PC);

  always_comb begin
    for (int i = 0; i < 64; i++) src[i] = 64'd0;
    for (int i = 0; i < 8; i++) src[i] = rf_r[i];
    src[K5]       = 64'd5;
    src[K128]     = 64'd128;
    src[K32767]   = 64'd32767;
    src[KM32768]  = 64'hFFFF_FFFF_FFFF_8000;
    src[K128000]  = 64'd128000;
    src[K2P47]    = 64'h0000_8000_0000_0000;
    src[K1048576] = 64'd1048576;
    src[K3125]    = 64'd3125;
    src[K76800]   = 64'd76800;
    src[K16384]   = 64'd16384;
    src[K32768]   = 64'd32768;
    src[K2097152] = 64'd2097152;
    src[K8192]    = 64'd8192;
    src[KHUMMAX]  = 64'd419430400;
    src[F_ADCP]   = {44'd0, cur_r.adc_p};
    src[F_ADCT]   = {44'd0, cur_r.adc_t};
    src[F_ADCH]   = {48'd0, cur_r.adc_h};
    src[F_T1]     = {48'd0, cfg.cal_temp[15:0]};
    src[F_T2]     = {{48{cfg.cal_temp[31]}}, cfg.cal_temp[31:16]};
    src[F_T3]     = {{48{cfg.cal_temp[47]}}, cfg.cal_temp[47:32]};
    src[F_P1]     = {48'd0, cfg.cal_press_a[15:0]};
    src[F_P2]     = {{48{cfg.cal_press_a[31]}}, cfg.cal_press_a[31:16]};
    src[F_P3]     = {{48{cfg.cal_press_a[47]}}, cfg.cal_press_a[47:32]};
    src[F_P4]     = {{48{cfg.cal_press_a[63]}}, cfg.cal_press_a[63:48]};
    src[F_P5]     = {{48{cfg.cal_press_b[15]}}, cfg.cal_press_b[15:0]};
    src[F_P6]     = {{48{cfg.cal_press_b[31]}}, cfg.cal_press_b[31:16]};
    src[F_P7]     = {{48{cfg.cal_press_b[47]}}, cfg.cal_press_b[47:32]};
    src[F_P8]     = {{48{cfg.cal_press_b[63]}}, cfg.cal_press_b[63:48]};
    src[F_P9]     = {{48{cfg.cal_press_c[15]}}, cfg.cal_press_c};
    src[F_H1]     = {56'd0, cfg.cal_hum[7:0]};
    src[F_H2]     = {{48{cfg.cal_hum[23]}}, cfg.cal_hum[23:8]};
    src[F_H3]     = {56'd0, cfg.cal_hum[31:24]};
    src[F_H4]     = {{52{cfg.cal_hum[43]}}, cfg.cal_hum[43:32]};
    src[F_H5]     = {{52{cfg.cal_hum[55]}}, cfg.cal_hum[55:44]};
    src[F_H6]     = {{56{cfg.cal_hum[63]}}, cfg.cal_hum[63:56]};
  end

  assign opa = src[uw.sa];
  assign opb = src[uw.sb];

  always_comb begin
    case (uw.op)
      OP_ADD:  alu_res = opa + opb;
      OP_SUB:  alu_res = opa - opb;
      OP_SHL:  alu_res = opa << uw.sh;
      OP_ASR:  alu_res = 64'($signed(opa) >>> uw.sh);
      OP_MIN:  alu_res = ($signed(opa) < $signed(opb)) ? opa : opb;
      OP_MAX:  alu_res = ($signed(opa) > $signed(opb)) ? opa : opb;
      default: alu_res = opa;
    endcase
  end

  // low 64 bits of the product from three 32x32 partial products
  assign mul_ph = (state_r == BK_MUL) ? mph_r : 2'd0;
  assign ma     = (mul_ph == 2'd2) ? opa[63:32] : opa[31:0];
  assign mb     = (mul_ph == 2'd1) ? opb[63:32] : opb[31:0];
  assign prod   = {32'd0, ma} * {32'd0, mb};
  assign acc_nxt = (mul_ph == 2'd0) ? prod : (acc_r + {prod[31:0], 32'd0});

  esc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (opa),
    .den   (opb),
    .done  (div_done),
    .quo   (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_EXEC;
      BK_EXEC: begin
        if (uw.op == OP_MUL) state_nxt = BK_MUL;
        else if (uw.op == OP_DIV) state_nxt = BK_DIV;
        else if (last) state_nxt = BK_EMIT;
      end
      BK_MUL: if (mph_r == 2'd2) state_nxt = last ? BK_EMIT : BK_EXEC;
      BK_DIV: if (div_done) state_nxt = last ? BK_EMIT : BK_EXEC;
      BK_EMIT: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    rf_we     = 1'b0;
    pc_adv    = 1'b0;
    acc_ld    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    wdata_raw = alu_res;
    case (state_r)
      BK_IDLE: pop = ~q_empty;
      BK_EXEC: begin
        if (uw.op == OP_MUL) begin
          acc_ld = 1'b1;
        end else if (uw.op == OP_DIV) begin
          div_start = 1'b1;
        end else begin
          rf_we  = 1'b1;
          pc_adv = 1'b1;
        end
      end
      BK_MUL: begin
        acc_ld    = 1'b1;
        wdata_raw = acc_nxt;
        rf_we     = (mph_r == 2'd2);
        pc_adv    = (mph_r == 2'd2);
      end
      BK_DIV: begin
        wdata_raw = div_quo;
        rf_we     = div_done;
        pc_adv    = div_done;
      end
      BK_EMIT: out_load = 1'b1;
      default: ;
    endcase
  end

  assign wdata = uw.w32 ? {{32{wdata_raw[31]}}, wdata_raw[31:0]} : wdata_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      pc_r    <= '0;
      mph_r   <= 2'd1;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= out_load;
      mph_r   <= (state_r == BK_MUL) ? (mph_r + 2'd1) : 2'd1;
      // hold the counter on the last step until the next item restarts it
      if (pop) pc_r <= '0;
      else if (pc_adv && !last) pc_r <= pc_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= q_head;
    if (acc_ld) acc_r <= acc_nxt;
    if (rf_we) rf_r[uw.dst] <= wdata;
    if (out_load) begin
      out_temperature_centi <= rf_r[3][15:0];
      out_pressure_q24_8    <= (rf_r[0] == 64'd0) ? 32'd0 : rf_r[1][31:0];
      out_pressure_div_zero <= (rf_r[0] == 64'd0);
      out_humidity_q22_10   <= cfg.hum_en ? rf_r[5][16:0] : 17'd0;
      out_humidity_valid    <= cfg.hum_en;
    end
  end

  assign out_valid = valid_r;

`ifndef SYNTH
  a_emit_before_beat: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> $past(state_r == BK_EMIT))
    else $error("result beat without emit state");
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= LAST_PC)
    else $error("microprogram counter out of range");
  a_no_hum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_humidity_valid) |-> (out_humidity_q22_10 == 17'd0))
    else $error("humidity reported on a chip without it");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == BK_EXEC && pc_r == 7'd0))
    else $error("item taken without restarting the program");
`endif

endmodule
`default_nettype wire

// File: bench/env_sensor_compensation_core_test.sv
// Self-checking bench for the sensor compensation core: directed and random bursts
// under several calibration settings and idle mixes. Depends on esc_pkg and the core.
`timescale 1ns / 1ps
module env_sensor_compensation_core_test;
  import esc_pkg::*;

  localparam logic [2:0] CFG_UNUSED = 3'd6;
  localparam int N_RANDOM = 1950;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [7:0] pm, pl, px, tm, tl, tx, hm, hl;
  } burst_t;

  typedef struct packed {
    logic [15:0] temp;
    logic [31:0] press;
    logic        divz;
    logic [16:0] hum;
    logic        hvalid;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  burst_t cur = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = CFG_HUM_EN;
  logic [63:0] cfg_wdata = '0;
  logic out_valid;
  logic [15:0] out_temperature_centi;
  logic [31:0] out_pressure_q24_8;
  logic out_pressure_div_zero;
  logic [16:0] out_humidity_q22_10;
  logic out_humidity_valid;

  cfg_t cal = '0;
  burst_t pending_bursts[$];
  reading_t expected_readings[$];
  int send_idle_pct = 0;
  int errors = 0;

  env_sensor_compensation_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_press_msb(cur.pm), .in_press_lsb(cur.pl), .in_press_xlsb(cur.px),
    .in_temp_msb(cur.tm), .in_temp_lsb(cur.tl), .in_temp_xlsb(cur.tx),
    .in_hum_msb(cur.hm), .in_hum_lsb(cur.hl),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_temperature_centi(out_temperature_centi),
    .out_pressure_q24_8(out_pressure_q24_8), .out_pressure_div_zero(out_pressure_div_zero),
    .out_humidity_q22_10(out_humidity_q22_10), .out_humidity_valid(out_humidity_valid)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic reading_t compensate(burst_t b, cfg_t c);
    reading_t r;
    int adc_p, adc_t, adc_h, t1, t2, t3, v1, v2, dt, tf, tc;
    int h1, h2, h3, h4, h5, h6, x, l, q;
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, a, bb, p, cc, dd;
    adc_p = {b.pm, b.pl, b.px[7:4]};
    adc_t = {b.tm, b.tl, b.tx[7:4]};
    adc_h = {b.hm, b.hl};
    t1 = c.cal_temp[15:0];
    t2 = $signed(c.cal_temp[31:16]);
    t3 = $signed(c.cal_temp[47:32]);
    v1 = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    dt = (adc_t >>> 4) - t1;
    v2 = (((dt * dt) >>> 12) * t3) >>> 14;
    tf = v1 + v2;
    tc = (tf * 5 + 128) >>> 8;
    if (tc > 32767) tc = 32767;
    if (tc < -32768) tc = -32768;
    r.temp = tc[15:0];

    p1 = c.cal_press_a[15:0];
    p2 = $signed(c.cal_press_a[31:16]);
    p3 = $signed(c.cal_press_a[47:32]);
    p4 = $signed(c.cal_press_a[63:48]);
    p5 = $signed(c.cal_press_b[15:0]);
    p6 = $signed(c.cal_press_b[31:16]);
    p7 = $signed(c.cal_press_b[47:32]);
    p8 = $signed(c.cal_press_b[63:48]);
    p9 = $signed(c.cal_press_c);
    a = longint'(tf) - 128000;
    bb = a * a * p6;
    bb = bb + ((a * p5) <<< 17);
    bb = bb + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((longint'(1) <<< 47) + a) * p1) >>> 33;
    r.press = '0;
    r.divz = (a == 0);
    if (a != 0) begin
      p = 1048576 - longint'(adc_p);
      p = (((p <<< 31) - bb) * 3125) / a;
      cc = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      dd = (p8 * p) >>> 19;
      p = ((p + cc + dd) >>> 8) + (p7 <<< 4);
      r.press = p[31:0];
    end

    r.hum = '0;
    r.hvalid = c.hum_en;
    if (c.hum_en) begin
      h1 = c.cal_hum[7:0];
      h2 = $signed(c.cal_hum[23:8]);
      h3 = c.cal_hum[31:24];
      h4 = $signed(c.cal_hum[43:32]);
      h5 = $signed(c.cal_hum[55:44]);
      h6 = $signed(c.cal_hum[63:56]);
      x = tf - 76800;
      l = (adc_h <<< 14) - (h4 <<< 20) - (h5 * x);
      l = (l + 16384) >>> 15;
      q = (((x * h6) >>> 10) * (((x * h3) >>> 11) + 32768)) >>> 10;
      q = (((q + 2097152) * h2) + 8192) >>> 14;
      x = l * q;
      x = x - (((((x >>> 15) * (x >>> 15)) >>> 7) * h1) >>> 4);
      if (x < 0) x = 0;
      if (x > 419430400) x = 419430400;
      q = x >>> 12;
      r.hum = q[16:0];
    end
    return r;
  endfunction

  // Driver: record the expectation of each accepted beat, then present the next
  always @(posedge clk) begin
    if (start && !busy)
      expected_readings.push_back(compensate(cur, cal));
    if (start && busy) begin
      start <= 1'b1;
    end else if (rst_n && pending_bursts.size() > 0 &&
                 $urandom_range(99, 0) >= send_idle_pct) begin
      start <= 1'b1;
      cur <= pending_bursts.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected reading temp=%h press=%h", $time,
                 out_temperature_centi, out_pressure_q24_8);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        if (want.temp !== out_temperature_centi) begin
          $display("%0t: temperature exp %h got %h", $time, want.temp, out_temperature_centi);
          errors++;
        end
        if (want.press !== out_pressure_q24_8) begin
          $display("%0t: pressure exp %h got %h", $time, want.press, out_pressure_q24_8);
          errors++;
        end
        if (want.divz !== out_pressure_div_zero) begin
          $display("%0t: div_zero exp %b got %b", $time, want.divz, out_pressure_div_zero);
          errors++;
        end
        if (want.hum !== out_humidity_q22_10) begin
          $display("%0t: humidity exp %h got %h", $time, want.hum, out_humidity_q22_10);
          errors++;
        end
        if (want.hvalid !== out_humidity_valid) begin
          $display("%0t: hum_valid exp %b got %b", $time, want.hvalid, out_humidity_valid);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HUM_EN:  cal.hum_en = data[0];
      CFG_TEMP:    cal.cal_temp = data[47:0];
      CFG_PRESS_A: cal.cal_press_a = data;
      CFG_PRESS_B: cal.cal_press_b = data;
      CFG_PRESS_C: cal.cal_press_c = data[15:0];
      CFG_HUM:     cal.cal_hum = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_bursts.size() > 0 || start || expected_readings.size() > 0)
      @(posedge clk);
  endtask

  // Calibration of a typical part; T, P, H2 jittered by +-jit, other H by +0..jit%40
  task automatic load_typical(int jit, logic hum);
    logic [15:0] c[12];
    logic [7:0] h1, h3, h6;
    logic [11:0] h4, h5;
    logic [15:0] h2;
    c[0] = 27504 + $urandom_range(2*jit, 0) - jit;
    c[1] = 26435 + $urandom_range(2*jit, 0) - jit;
    c[2] = -1000 + $urandom_range(2*jit, 0) - jit;
    c[3] = 36477 + $urandom_range(2*jit, 0) - jit;
    c[4] = -10685 + $urandom_range(2*jit, 0) - jit;
    c[5] = 3024 + $urandom_range(2*jit, 0) - jit;
    c[6] = 2855 + $urandom_range(2*jit, 0) - jit;
    c[7] = 140 + $urandom_range(2*jit, 0) - jit;
    c[8] = -7 + $urandom_range(2*jit, 0) - jit;
    c[9] = 15500 + $urandom_range(2*jit, 0) - jit;
    c[10] = -14600 + $urandom_range(2*jit, 0) - jit;
    c[11] = 6000 + $urandom_range(2*jit, 0) - jit;
    h1 = 75 + $urandom_range(jit % 40, 0);
    h2 = 362 + $urandom_range(2*jit, 0) - jit;
    h3 = $urandom_range(jit % 40, 0);
    h4 = 313 + $urandom_range(jit % 40, 0);
    h5 = 50 + $urandom_range(jit % 40, 0);
    h6 = 30 + $urandom_range(jit % 40, 0);
    write_reg(CFG_HUM_EN, {63'd0, hum});
    write_reg(CFG_TEMP, {16'd0, c[2], c[1], c[0]});
    write_reg(CFG_PRESS_A, {c[6], c[5], c[4], c[3]});
    write_reg(CFG_PRESS_B, {c[10], c[9], c[8], c[7]});
    write_reg(CFG_PRESS_C, {48'd0, c[11]});
    write_reg(CFG_HUM, {h6, h5, h4, h3, h2, h1});
  endtask

  task automatic load_random();
    write_reg(CFG_HUM_EN, {$urandom, $urandom});
    write_reg(CFG_TEMP, {$urandom, $urandom});
    write_reg(CFG_PRESS_A, {$urandom, $urandom});
    write_reg(CFG_PRESS_B, {$urandom, $urandom});
    write_reg(CFG_PRESS_C, {$urandom, $urandom});
    write_reg(CFG_HUM, {$urandom, $urandom});
  endtask

  function automatic burst_t make_burst(int wild_pct);
    burst_t b;
    logic [19:0] ap, at;
    logic [15:0] ah;
    if ($urandom_range(99, 0) < wild_pct) begin
      b = {$urandom, $urandom};
    end else begin
      ap = 20'd415148 + $urandom_range(200000, 0) - 100000;
      at = 20'd519888 + $urandom_range(120000, 0) - 60000;
      ah = 16'd30000 + $urandom_range(30000, 0) - 15000;
      b = {ap[19:12], ap[11:4], ap[3:0], 4'($urandom), at[19:12], at[11:4], at[3:0],
           4'($urandom), ah[15:8], ah[7:0]};
    end
    return b;
  endfunction

  initial begin
    int idle_mix[4] = '{0, 59, 0, 24};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset calibration: zero divisor and no humidity
    pending_bursts.push_back('0);
    pending_bursts.push_back('1);
    wait_drained();
    load_typical(0, 1'b1);
    pending_bursts.push_back('0);
    pending_bursts.push_back('1);
    pending_bursts.push_back({8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00, 8'h75, 8'h30});
    pending_bursts.push_back({8'h00, 8'h00, 8'h0F, 8'hFF, 8'hFF, 8'hF0, 8'hFF, 8'hFF});
    pending_bursts.push_back({8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h0F, 8'h00, 8'h00});
    wait_drained();
    // Saturating coefficients drive temperature and humidity into their clamps
    write_reg(CFG_TEMP, {16'h7FFF, 16'h7FFF, 16'h0000});
    write_reg(CFG_HUM, 64'h7F7FF7FF_FF7FFFFF);
    write_reg(CFG_UNUSED, '1);
    pending_bursts.push_back('0);
    pending_bursts.push_back('1);
    pending_bursts.push_back({8'h80, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0, 8'h80, 8'h00});
    wait_drained();
    write_reg(CFG_TEMP, {16'h8000, 16'h8000, 16'hFFFF});
    write_reg(CFG_PRESS_A, '1);
    write_reg(CFG_PRESS_B, {4{16'h8000}});
    write_reg(CFG_PRESS_C, 64'h8000);
    write_reg(CFG_HUM, 64'h80800800_00800000);
    pending_bursts.push_back('0);
    pending_bursts.push_back('1);
    pending_bursts.push_back({8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0, 8'hFF, 8'hFF});
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = idle_mix[ph % 4];
      case (ph % 4)
        0: load_typical(ph * 30, 1'b1);
        1: load_typical(ph * 5, ph[2]);
        2: load_random();
        default: load_typical(3, 1'b1);
      endcase
      for (int i = 0; i < N_RANDOM / 8; i++) begin
        pending_bursts.push_back(make_burst(ph % 4 == 2 ? 60 : 15));
        // Hold off mid-phase until every reading is back
        if (i == N_RANDOM / 16)
          wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #60ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
